// ----- rtl/smld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smld_pkg: shared types and constants of the length-prefixed deframer
// Holds the phase and result codes, the header constants and the result
// record passed between the parser and the result register.
// ----------------------------------------------------------------------------
package smld_pkg;

    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned REG_IDX_W = PADDR_W - 2;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned HDR_BYTES = 8;
    localparam int unsigned CNT_W     = 3;

    localparam logic [REG_IDX_W-1:0] REG_MAX_PAYLOAD_LEN = '0;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65528;
    localparam logic [63:0]      HEALTH_WORD   = 64'hFEFE_FEFE_0000_0000;
    localparam logic [31:0]      SYNC_MARKER   = 32'hFFFF_FFFF;

    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_RECONNECT = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_EMPTY    = 3'd1,
        KIND_ECHO     = 3'd2,
        KIND_SYNC_ERR = 3'd3,
        KIND_OVERSIZE = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic       last;
    } t_result;

endpackage

// ----- rtl/smld_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smld_cfg_regs: configuration register file
// APB-style slave holding the largest accepted payload length.
// ----------------------------------------------------------------------------
module smld_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [smld_pkg::PADDR_W-1:0] paddr,
    input  logic [smld_pkg::PDATA_W-1:0] pwdata,
    output logic [smld_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [smld_pkg::LEN_W-1:0]   o_max_len
);
    import smld_pkg::*;

    logic [LEN_W-1:0]     r_max_len;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_MAX_PAYLOAD_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (wr_en) begin
            r_max_len <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_MAX_PAYLOAD_LEN) begin
            prdata[LEN_W-1:0] = r_max_len;
        end
    end

    assign pready    = 1'b1;
    assign o_max_len = r_max_len;

endmodule

// ----- rtl/smld_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smld_parser: input register and header/payload parser
// Registers one beat, then decodes it against the parser state in one pass
// and hands at most one result to the result register.
// ----------------------------------------------------------------------------
module smld_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_op,
    input  logic [7:0]                 i_rx_byte,
    input  logic [smld_pkg::LEN_W-1:0] i_max_len,
    input  logic                       i_out_free,
    output logic                       o_res_load,
    output smld_pkg::t_result          o_res
);
    import smld_pkg::*;

    logic             r_in_valid;
    logic             r_in_op;
    logic [7:0]       r_in_byte;
    t_phase           r_phase;
    t_phase           n_phase;
    logic [CNT_W-1:0] r_hdr_cnt;
    logic [CNT_W-1:0] n_hdr_cnt;
    logic [7:0]       r_hdr [HDR_BYTES-1];
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] n_rem;
    logic [LEN_W-1:0] rem_dec;
    logic [63:0]      full_word;
    logic [LEN_W-1:0] hdr_len;
    logic             hdr_done;
    logic             is_health;
    logic             bad_marker;
    logic             oversize;
    logic             advance;
    logic             hdr_wr;
    logic             res_valid;
    t_result          res;

    assign advance    = r_in_valid && i_out_free;
    assign o_in_ready = !r_in_valid || i_out_free;

    always_comb begin
        full_word = '0;
        for (int i = 0; i < HDR_BYTES - 1; i++) begin
            full_word[8*i +: 8] = r_hdr[i];
        end
        full_word[63:56] = r_in_byte;
    end

    assign hdr_len    = full_word[LEN_W-1:0];
    assign hdr_done   = (r_hdr_cnt == CNT_W'(HDR_BYTES - 1));
    assign is_health  = (full_word == HEALTH_WORD);
    assign bad_marker = (full_word[63:32] != SYNC_MARKER);
    assign oversize   = (hdr_len > i_max_len);
    assign rem_dec    = (r_rem != '0) ? (r_rem - LEN_W'(1)) : r_rem;

    always_comb begin
        n_phase = r_phase;
        if (r_in_op == OP_RECONNECT) begin
            n_phase = PH_HEADER;
        end else begin
            case (r_phase)
                PH_PAYLOAD: begin
                    if (rem_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (hdr_done && !is_health) begin
                        if (bad_marker || oversize) begin
                            n_phase = PH_DROP;
                        end else if (hdr_len != '0) begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        n_hdr_cnt        = r_hdr_cnt;
        n_rem            = r_rem;
        hdr_wr           = 1'b0;
        res_valid        = 1'b0;
        res.kind         = KIND_DATA;
        res.payload_byte = '0;
        res.last         = 1'b0;
        if (r_in_op == OP_RECONNECT) begin
            n_hdr_cnt = '0;
            n_rem     = '0;
        end else begin
            case (r_phase)
                PH_PAYLOAD: begin
                    n_rem            = rem_dec;
                    res_valid        = 1'b1;
                    res.payload_byte = r_in_byte;
                    res.last         = (r_rem <= LEN_W'(1));
                end
                PH_HEADER: begin
                    if (!hdr_done) begin
                        hdr_wr    = 1'b1;
                        n_hdr_cnt = r_hdr_cnt + CNT_W'(1);
                    end else begin
                        n_hdr_cnt = '0;
                        if (is_health) begin
                            res_valid = 1'b1;
                            res.kind  = KIND_ECHO;
                        end else if (bad_marker) begin
                            res_valid = 1'b1;
                            res.kind  = KIND_SYNC_ERR;
                        end else if (oversize) begin
                            res_valid = 1'b1;
                            res.kind  = KIND_OVERSIZE;
                        end else if (hdr_len == '0) begin
                            res_valid = 1'b1;
                            res.kind  = KIND_EMPTY;
                        end else begin
                            n_rem = hdr_len;
                        end
                    end
                end
                default: begin
                    n_rem = r_rem;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_op   <= i_op;
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_rem     <= '0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_rem     <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && hdr_wr) begin
            r_hdr[r_hdr_cnt] <= r_in_byte;
        end
    end

    assign o_res_load = advance && res_valid;
    assign o_res      = res;

endmodule

// ----- rtl/smld_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smld_out_reg: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module smld_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  smld_pkg::t_result i_res,
    input  logic              i_out_ready,
    output logic              o_out_free,
    output logic              o_out_valid,
    output smld_pkg::t_result o_res
);
    import smld_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_out_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/sync_marked_length_deframer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_marked_length_deframer_top: length-prefixed message deframer
// Splits a received byte stream into messages with an 8-byte header of
// length and sync marker, and streams out payload bytes and status results.
//
//   Channel  Direction  Handshake                  Beat contents
//   input    in         i_in_valid / o_in_ready    i_op, i_rx_byte
//   output   out        o_out_valid / i_out_ready  o_kind, o_payload_byte, o_last
//   config   in         APB psel/penable/pready    max_payload_len at 0x0
//
// One beat is accepted every cycle when the output side keeps up.
// An accepted beat is held in the input register and decoded from there;
// its result is loaded into the result register, which drives the output.
// The input register and the single result register set the rate.
// Reset clears the parser state and both valid flags.
// A stalled output holds the result and stops the parser behind it.
// ----------------------------------------------------------------------------
module sync_marked_length_deframer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_op,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_kind,
    output logic [7:0]                   o_payload_byte,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [smld_pkg::PADDR_W-1:0] paddr,
    input  logic [smld_pkg::PDATA_W-1:0] pwdata,
    output logic [smld_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import smld_pkg::*;

    logic [LEN_W-1:0] max_len;
    logic             out_free;
    logic             res_load;
    t_result          parser_res;
    t_result          out_res;

    smld_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    smld_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_rx_byte  (i_rx_byte),
        .i_max_len  (max_len),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (parser_res)
    );

    smld_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_load),
        .i_res       (parser_res),
        .i_out_ready (i_out_ready),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_last         = out_res.last;

endmodule

// ----- rtl/smld_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smld_checker: port-level checks of the deframer
// Watches the result channel and reset behavior of the top level.
// ----------------------------------------------------------------------------
module smld_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_kind,
    input logic [7:0] o_payload_byte,
    input logic       o_last
);
    import smld_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_payload_byte) && $stable(o_last))
        else $error("Stalled result beat changed.");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_DATA) |-> (o_payload_byte == 8'd0) && !o_last)
        else $error("Status beat carries payload or last flag.");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == KIND_DATA) || (o_kind == KIND_EMPTY)
            || (o_kind == KIND_ECHO) || (o_kind == KIND_SYNC_ERR)
            || (o_kind == KIND_OVERSIZE))
        else $error("Result kind out of range.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid after reset.");

endmodule

bind sync_marked_length_deframer_top smld_checker u_smld_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_kind         (o_kind),
    .o_payload_byte (o_payload_byte),
    .o_last         (o_last)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of sync_marked_length_deframer_top
// A short table of directed frames is followed by random frames under several
// length limits. Every input beat is run through a deframer model kept here,
// and each output beat is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;

    import smld_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned BEATS_PER_PHASE = 100;
    localparam int unsigned DRAIN_CYCLES    = 6;

    localparam logic [PADDR_W-1:0] MAX_LEN_ADDR = {REG_MAX_PAYLOAD_LEN, 2'b00};
    localparam t_result NO_RESULT = '{KIND_DATA, 8'h00, 1'b0};

    typedef enum logic [1:0] {
        STIM_BYTE      = 2'd0,
        STIM_WORD      = 2'd1,
        STIM_RECONNECT = 2'd2
    } t_stim_kind;

    typedef struct packed {
        t_stim_kind  sk;
        logic [63:0] val;
        bit          typed;
        bit          has;
        t_result     res;
    } t_stim_row;

    localparam t_stim_row DIRECTED [24] = '{
        '{STIM_WORD, 64'hFFFF_FFFF_0000_0002, 1'b1, 1'b0, NO_RESULT},
        '{STIM_BYTE, 64'h00, 1'b1, 1'b1, '{KIND_DATA, 8'h00, 1'b0}},
        '{STIM_BYTE, 64'hFF, 1'b1, 1'b1, '{KIND_DATA, 8'hFF, 1'b1}},
        '{STIM_WORD, 64'hFFFF_FFFF_0000_0000, 1'b1, 1'b1, '{KIND_EMPTY, 8'h00, 1'b0}},
        '{STIM_WORD, 64'hFEFE_FEFE_0000_0000, 1'b1, 1'b1, '{KIND_ECHO, 8'h00, 1'b0}},
        '{STIM_WORD, 64'hFFFF_FFFF_0000_FFF8, 1'b1, 1'b0, NO_RESULT},
        '{STIM_BYTE, 64'h5A, 1'b0, 1'b0, NO_RESULT},
        '{STIM_BYTE, 64'hA5, 1'b0, 1'b0, NO_RESULT},
        '{STIM_RECONNECT, 64'h0, 1'b1, 1'b0, NO_RESULT},
        '{STIM_BYTE, 64'h01, 1'b0, 1'b0, NO_RESULT},
        '{STIM_BYTE, 64'h00, 1'b0, 1'b0, NO_RESULT},
        '{STIM_RECONNECT, 64'h0, 1'b1, 1'b0, NO_RESULT},
        '{STIM_WORD, 64'hFFFF_FFFF_0000_0001, 1'b1, 1'b0, NO_RESULT},
        '{STIM_BYTE, 64'h80, 1'b0, 1'b0, NO_RESULT},
        '{STIM_WORD, 64'hFFFF_FFFF_0000_FFF9, 1'b1, 1'b1, '{KIND_OVERSIZE, 8'h00, 1'b0}},
        '{STIM_BYTE, 64'h3C, 1'b1, 1'b0, NO_RESULT},
        '{STIM_WORD, 64'hFEFE_FEFE_0000_0000, 1'b1, 1'b0, NO_RESULT},
        '{STIM_RECONNECT, 64'h0, 1'b1, 1'b0, NO_RESULT},
        '{STIM_WORD, 64'hFEFE_FEFE_0000_0001, 1'b1, 1'b1, '{KIND_SYNC_ERR, 8'h00, 1'b0}},
        '{STIM_RECONNECT, 64'h0, 1'b1, 1'b0, NO_RESULT},
        '{STIM_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, '{KIND_OVERSIZE, 8'h00, 1'b0}},
        '{STIM_RECONNECT, 64'h0, 1'b1, 1'b0, NO_RESULT},
        '{STIM_WORD, 64'h7FFF_FFFF_0000_0003, 1'b1, 1'b1, '{KIND_SYNC_ERR, 8'h00, 1'b0}},
        '{STIM_RECONNECT, 64'h0, 1'b1, 1'b0, NO_RESULT}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_op;
    logic [7:0]           i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [2:0]           o_kind;
    logic [7:0]           o_payload_byte;
    logic                 o_last;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    sync_marked_length_deframer_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Deframer model state and the length limit it applies.
    logic [31:0] lim_len;
    t_phase      frame_phase;
    logic [2:0]  hdr_cnt;
    logic [63:0] hdr_word;
    logic [31:0] left_len;

    t_result     pending_results [$];
    bit          beat_typed;
    bit          beat_has;
    t_result     beat_res;
    bit          calm_in;
    bit          calm_out;
    int unsigned live_beats;
    int unsigned n_err;
    int unsigned cycle_count;

    task automatic report(input string msg);
        if (n_err < 40) begin
            $display("ERROR: %0t ns: %s", $time, msg);
        end
        n_err++;
    endtask

    task automatic clear_parser();
        frame_phase = PH_HEADER;
        hdr_cnt     = '0;
        hdr_word    = '0;
        left_len    = '0;
    endtask

    task automatic deframe_step(input logic op, input logic [7:0] b,
                                output bit got, output t_result r);
        logic [63:0] w;
        got = 1'b0;
        r   = NO_RESULT;
        if (op == OP_RECONNECT) begin
            clear_parser();
        end else if (frame_phase == PH_PAYLOAD) begin
            got            = 1'b1;
            r.payload_byte = b;
            r.last         = (left_len <= 32'd1);
            if (left_len != 32'd0) begin
                left_len = left_len - 32'd1;
            end
            if (left_len == 32'd0) begin
                frame_phase = PH_HEADER;
            end
        end else if (frame_phase == PH_HEADER) begin
            hdr_word = hdr_word | (64'(b) << (8 * hdr_cnt));
            if (hdr_cnt != 3'd7) begin
                hdr_cnt = hdr_cnt + 3'd1;
            end else begin
                w        = hdr_word;
                hdr_cnt  = '0;
                hdr_word = '0;
                got      = 1'b1;
                if (w == HEALTH_WORD) begin
                    r.kind = KIND_ECHO;
                end else if (w[63:32] != SYNC_MARKER) begin
                    r.kind      = KIND_SYNC_ERR;
                    frame_phase = PH_DROP;
                end else if (w[31:0] > lim_len) begin
                    r.kind      = KIND_OVERSIZE;
                    frame_phase = PH_DROP;
                end else if (w[31:0] == 32'd0) begin
                    r.kind = KIND_EMPTY;
                end else begin
                    got         = 1'b0;
                    left_len    = w[31:0];
                    frame_phase = PH_PAYLOAD;
                end
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sync_marked_length_deframer_top: mismatch");
            $finish;
        end
    end

    // Model update on every accepted input beat, check on every output beat.
    always @(posedge i_clk) begin
        bit      got;
        t_result r;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (!(i_op == OP_BYTE && frame_phase == PH_DROP)) begin
                    live_beats++;
                end
                deframe_step(i_op, i_rx_byte, got, r);
                if (beat_typed) begin
                    got = beat_has;
                    r   = beat_res;
                end
                if (got) begin
                    pending_results.push_back(r);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report($sformatf("unexpected beat kind %0d byte %02h last %0d",
                                     o_kind, o_payload_byte, o_last));
                end else begin
                    r = pending_results.pop_front();
                    if (o_kind !== r.kind || o_payload_byte !== r.payload_byte
                            || o_last !== r.last) begin
                        report($sformatf("kind %0d/%0d byte %02h/%02h last %0d/%0d (got/exp)",
                                         o_kind, r.kind, o_payload_byte, r.payload_byte,
                                         o_last, r.last));
                    end
                end
            end
        end
    end

    initial begin
        int unsigned n;
        forever begin
            n = calm_out ? 0 : $urandom_range(0, 4);
            repeat (n) @(negedge i_clk) i_out_ready <= 1'b0;
            @(negedge i_clk) i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    task automatic drive_beat(input logic op, input logic [7:0] b, input bit typed,
                              input bit has, input t_result res);
        int unsigned gap;
        gap = calm_in ? 0 : $urandom_range(0, 4);
        repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_rx_byte  <= b;
        beat_typed <= typed;
        beat_has   <= has;
        beat_res   <= res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_byte(input logic [7:0] b);
        drive_beat(OP_BYTE, b, 1'b0, 1'b0, NO_RESULT);
    endtask

    task automatic send_reconnect();
        drive_beat(OP_RECONNECT, 8'($urandom), 1'b0, 1'b0, NO_RESULT);
    endtask

    task automatic send_header(input logic [63:0] w);
        for (int k = 0; k < 8; k++) begin
            send_byte(w[8*k +: 8]);
        end
    endtask

    // After a framing error the block ignores input until a reconnect.
    task automatic drop_tail();
        int unsigned n;
        n = $urandom_range(0, 4);
        repeat (n) send_byte(8'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            send_header(HEALTH_WORD);
        end
        send_reconnect();
    endtask

    task automatic settle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_len(input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LEN_ADDR;
        pwdata  <= v;
        @(negedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        lim_len = v;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== v) begin
            report($sformatf("max_payload_len reads %08h, written %08h", prdata, v));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_sequence();
        int unsigned pick;
        int unsigned len;
        int unsigned top;
        int unsigned n;
        logic [63:0] w;
        calm_in  = ($urandom_range(0, 7) == 0);
        calm_out = ($urandom_range(0, 7) == 0);
        pick     = $urandom_range(0, 99);
        top      = (lim_len < 32'd24) ? lim_len : 24;
        if (pick < 50 && top != 0) begin
            len = ($urandom_range(0, 5) == 0) ? top : $urandom_range(1, top);
            send_header({SYNC_MARKER, len});
            repeat (len) send_byte(8'($urandom));
        end else if (pick < 60) begin
            send_header({SYNC_MARKER, 32'd0});
        end else if (pick < 66) begin
            send_header(HEALTH_WORD);
        end else if (pick < 74) begin
            w = {$urandom, $urandom};
            if (w[63:32] == SYNC_MARKER) begin
                w[32] = 1'b0;
            end
            send_header(w);
            drop_tail();
        end else if (pick < 82 && lim_len != 32'hFFFF_FFFF) begin
            len = ($urandom_range(0, 1) == 0) ? lim_len + 32'd1
                                              : $urandom_range(32'hFFFF_FFFF, lim_len + 32'd1);
            send_header({SYNC_MARKER, len});
            drop_tail();
        end else if (pick < 90 && lim_len >= 32'd2) begin
            // A long message cut short by a reconnect.
            len = ($urandom_range(0, 1) == 0) ? lim_len : $urandom_range(lim_len, 2);
            send_header({SYNC_MARKER, len});
            n = $urandom_range(0, (len - 1 < 6) ? len - 1 : 6);
            repeat (n) send_byte(8'($urandom));
            send_reconnect();
        end else if (pick < 95) begin
            n = $urandom_range(1, 7);
            repeat (n) send_byte(8'($urandom));
            send_reconnect();
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) begin
                drive_beat(($urandom_range(0, 7) == 0) ? OP_RECONNECT : OP_BYTE,
                           8'($urandom), 1'b0, 1'b0, NO_RESULT);
            end
            send_reconnect();
        end
    endtask

    initial begin
        t_stim_row   row;
        logic [31:0] limits [6];
        int unsigned start;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_BYTE;
        i_rx_byte   = 8'h00;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        beat_typed  = 1'b0;
        beat_has    = 1'b0;
        beat_res    = NO_RESULT;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        live_beats  = 0;
        n_err       = 0;
        cycle_count = 0;
        lim_len     = MAX_LEN_RESET;
        clear_parser();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            case (row.sk)
                STIM_BYTE: begin
                    drive_beat(OP_BYTE, row.val[7:0], row.typed, row.has, row.res);
                end
                STIM_RECONNECT: begin
                    drive_beat(OP_RECONNECT, 8'h00, row.typed, row.has, row.res);
                end
                default: begin
                    for (int k = 0; k < 8; k++) begin
                        drive_beat(OP_BYTE, row.val[8*k +: 8], row.typed,
                                   row.has && (k == 7), row.res);
                    end
                end
            endcase
        end
        settle();

        limits = '{32'd0, 32'd5, 32'hFFFF_FFFF, 32'($urandom_range(8, 40)), 32'd1,
                   32'($urandom)};
        foreach (limits[p]) begin
            set_max_len(limits[p]);
            start = live_beats;
            while (live_beats - start < BEATS_PER_PHASE) begin
                run_sequence();
            end
            settle();
        end

        if (pending_results.size() != 0) begin
            report($sformatf("%0d expected results never arrived", pending_results.size()));
        end
        if (n_err == 0) begin
            $display("sync_marked_length_deframer_top: match");
        end else begin
            $display("sync_marked_length_deframer_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/smld_pkg.sv
rtl/smld_cfg_regs.sv
rtl/smld_parser.sv
rtl/smld_out_reg.sv
rtl/sync_marked_length_deframer_top.sv
rtl/smld_checker.sv
tb/tb_top.sv
